// ----- src/pmst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared types and constants for the power monitor / self-test sequencer.
// ----------------------------------------------------------------------------
package pmst_pkg;

  localparam int DELTA_W = 10;
  localparam int TIME_W  = 16;
  localparam int N_AP    = 5;
  localparam int N_ATHR  = 5;
  localparam int N_DIG   = 2;

  // Self-test windows, elapsed ms, inclusive bounds
  localparam logic [TIME_W-1:0] AP_LO [N_AP] =
    '{16'd24700, 16'd25230, 16'd25460, 16'd25620, 16'd25800};
  localparam logic [TIME_W-1:0] AP_HI [N_AP] =
    '{16'd25180, 16'd25350, 16'd25550, 16'd25750, 16'd25950};
  localparam logic [TIME_W-1:0] ATHR_LO [N_ATHR] =
    '{16'd26160, 16'd26700, 16'd26960, 16'd27110, 16'd27320};
  localparam logic [TIME_W-1:0] ATHR_HI [N_ATHR] =
    '{16'd26600, 16'd26850, 16'd27050, 16'd27220, 16'd27720};
  localparam logic [TIME_W-1:0] DIG_LO [N_DIG] = '{16'd25230, 16'd29350};
  localparam logic [TIME_W-1:0] DIG_HI [N_DIG] = '{16'd28200, 16'd29750};

  localparam logic [TIME_W-1:0] TEST_LEN_RST  = 16'd30000;
  localparam logic [TIME_W-1:0] OUTAGE_LIM_RST = 16'd10;

  typedef enum logic [1:0] {
    BUS_FAIL_WARN = 2'd0,
    BUS_FUNC_TEST = 2'd1,
    BUS_NORMAL    = 2'd2
  } bus_status_t;

  // Register word indexes on the config port
  typedef enum logic {
    REG_TEST_LEN   = 1'b0,
    REG_OUTAGE_LIM = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta_ms;
    logic               powered;
    logic               fault_active;
    logic               gear_pressed_own;
    logic               gear_pressed_opposite;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] outage_time;
    logic              supply_fault;
    logic [TIME_W-1:0] test_countdown;
    logic              dig_valid;
  } state_t;

  typedef struct packed {
    logic        healthy;
    logic        ap_light;
    logic        athr_light;
    bus_status_t bus_status;
    logic        test_running;
  } result_t;

  typedef struct packed {
    logic ap_on;
    logic athr_on;
    logic dig_on;
  } win_t;

endpackage

// ----- src/pmst_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmst_window
// Elapsed self-test time and the fixed AP / A/THR / bus-test window decode.
// ----------------------------------------------------------------------------
module pmst_window
  import pmst_pkg::*;
(
  input  logic [TIME_W-1:0] test_len,
  input  logic [TIME_W-1:0] countdown,
  output win_t              win
);

  logic [TIME_W:0]   elapsed_w;
  logic [TIME_W-1:0] elapsed;
  logic              neg;
  logic              ap_hit;
  logic              athr_hit;
  logic              dig_hit;

  // countdown above length => negative elapsed, nothing matches
  assign elapsed_w = {1'b0, test_len} - {1'b0, countdown};
  assign neg       = elapsed_w[TIME_W];
  assign elapsed   = elapsed_w[TIME_W-1:0];

  always_comb begin
    ap_hit   = 1'b0;
    athr_hit = 1'b0;
    dig_hit  = 1'b0;
    for (int i = 0; i < N_AP; i++) begin
      ap_hit = ap_hit | ((elapsed >= AP_LO[i]) && (elapsed <= AP_HI[i]));
    end
    for (int i = 0; i < N_ATHR; i++) begin
      athr_hit = athr_hit | ((elapsed >= ATHR_LO[i]) && (elapsed <= ATHR_HI[i]));
    end
    for (int i = 0; i < N_DIG; i++) begin
      dig_hit = dig_hit | ((elapsed >= DIG_LO[i]) && (elapsed <= DIG_HI[i]));
    end
  end

  assign win.ap_on   = ap_hit & ~neg;
  assign win.athr_on = athr_hit & ~neg;
  assign win.dig_on  = dig_hit & ~neg;

endmodule

// ----- src/pmst_tick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmst_tick
// One tick of power monitoring and countdown: next state and result.
// ----------------------------------------------------------------------------
module pmst_tick
  import pmst_pkg::*;
(
  input  item_t             item,
  input  state_t            cur,
  input  logic [TIME_W-1:0] test_len,
  input  logic [TIME_W-1:0] outage_lim,
  output state_t            nxt,
  output result_t           res
);

  logic [TIME_W:0]   outage_sum;
  logic [TIME_W-1:0] outage_mid;
  logic              fault_mid;
  logic              restore;
  logic [TIME_W-1:0] cd_mid;
  logic [TIME_W-1:0] delta_ext;
  logic [TIME_W-1:0] cd_new;
  logic              complete;
  logic              dig_new;
  logic              healthy;
  win_t              win;

  assign delta_ext  = {{(TIME_W-DELTA_W){1'b0}}, item.delta_ms};
  assign outage_sum = {1'b0, cur.outage_time} + {1'b0, delta_ext};

  always_comb begin
    if (!item.powered) begin
      outage_mid = outage_sum[TIME_W] ? {TIME_W{1'b1}} : outage_sum[TIME_W-1:0];
    end else begin
      outage_mid = cur.outage_time;
    end
  end

  assign fault_mid = cur.supply_fault | (outage_mid > outage_lim);
  assign restore   = item.powered & fault_mid;

  // reload on power return with both gear flags, then count down to zero
  assign cd_mid = (restore && item.gear_pressed_own && item.gear_pressed_opposite) ?
                  test_len : cur.test_countdown;
  assign cd_new = (cd_mid > delta_ext) ? (cd_mid - delta_ext) : '0;

  pmst_window u_window (
    .test_len  (test_len),
    .countdown (cd_new),
    .win       (win)
  );

  assign complete = (cd_new == '0);
  assign dig_new  = complete ? cur.dig_valid : win.dig_on;
  assign healthy  = ~item.fault_active & ~(fault_mid & ~restore) & complete;

  assign nxt.outage_time    = restore ? '0 : outage_mid;
  assign nxt.supply_fault   = fault_mid & ~restore;
  assign nxt.test_countdown = cd_new;
  assign nxt.dig_valid      = dig_new;

  assign res.healthy      = healthy;
  assign res.ap_light     = ~complete & win.ap_on;
  assign res.athr_light   = ~complete & win.athr_on;
  assign res.bus_status   = healthy ? BUS_NORMAL : (dig_new ? BUS_FUNC_TEST : BUS_FAIL_WARN);
  assign res.test_running = ~complete;

endmodule

// ----- src/power_monitor_self_test_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_monitor_self_test_sequencer_core
// Power outage monitor with supply-fault latch and timed self-test sequencer.
// ----------------------------------------------------------------------------
// A request is held in the input register, then its result in the result register.
// Throughput: 1 request per cycle while out_tready is high; the tick update
//   is one combinational pass from the input and state registers into res_r.
// Reset (rst_n low, synchronous): pipeline empty, outage time, supply fault,
//   countdown and bus-test validity cleared; test length 30000 ms, outage
//   limit 10 ms.
module power_monitor_self_test_sequencer_core
  import pmst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] delta_ms, [10] powered, [11] fault_active, [12] gear_pressed_own,
  // [13] gear_pressed_opposite, [15:14] zero
  input  logic [15:0] in_tdata,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] healthy, [1] ap_light, [2] athr_light, [4:3] bus_status,
  // [5] test_running, [7:6] zero
  output logic [7:0]  out_tdata,
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------------------
  // Config registers (word addressed, byte lanes ignored)
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] test_len_r;
  logic [TIME_W-1:0] outage_lim_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_len_r   <= TEST_LEN_RST;
      outage_lim_r <= OUTAGE_LIM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TEST_LEN:   test_len_r   <= cfg_pwdata[TIME_W-1:0];
        REG_OUTAGE_LIM: outage_lim_r <= cfg_pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TEST_LEN:   cfg_prdata = {16'd0, test_len_r};
      REG_OUTAGE_LIM: cfg_prdata = {16'd0, outage_lim_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: input stage feeds the result stage whenever the result
  // register is empty or being drained this cycle.
  // ---------------------------------------------------------------------------
  logic    in_v_r;
  item_t   item_r;
  logic    out_v_r;
  result_t res_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  logic    adv;
  logic    in_acc;

  assign adv       = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // unpack request fields, lowest bit first
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.delta_ms              <= in_tdata[9:0];
      item_r.powered               <= in_tdata[10];
      item_r.fault_active          <= in_tdata[11];
      item_r.gear_pressed_own      <= in_tdata[12];
      item_r.gear_pressed_opposite <= in_tdata[13];
    end
  end

  // ---------------------------------------------------------------------------
  // Tick evaluation: state is committed together with the result so the next
  // request sees the updated outage time, fault latch and countdown.
  // ---------------------------------------------------------------------------
  pmst_tick u_tick (
    .item       (item_r),
    .cur        (state_r),
    .test_len   (test_len_r),
    .outage_lim (outage_lim_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, res_r.test_running, res_r.bus_status,
                       res_r.athr_light, res_r.ap_light, res_r.healthy};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a latched supply fault always has outage time behind it
  a_fault_has_outage: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.supply_fault |-> (state_r.outage_time != '0))
    else $error("supply fault latched with zero outage time");

  // healthy and test running exclude each other
  a_healthy_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(res_r.healthy && res_r.test_running))
    else $error("healthy reported while self test runs");

  // lights only during the test, and AP / A/THR windows never overlap
  a_lights: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.ap_light || res_r.athr_light)) |->
      (res_r.test_running && !(res_r.ap_light && res_r.athr_light)))
    else $error("test light outside its window");

  // a result is emitted only in the cycle after the input stage advanced
  a_out_from_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(adv))
    else $error("result valid without a request");

endmodule

// ----- tb/sv/power_monitor_self_test_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_monitor_self_test_sequencer_core_tb
// Drives time ticks into the power monitor / self-test sequencer and predicts
// every status word in a scoreboard. It covers outage build-up and saturation,
// the supply-fault latch and release, armed self tests with small steps
// through the AP, A/THR and bus-test windows, and register changes between
// phases, both at the range limits and at random.
// ----------------------------------------------------------------------------

import pmst_pkg::*;

class sequencer_scoreboard;
  // register copies
  int unsigned test_len;
  int unsigned outage_lim;
  // monitor state
  int unsigned outage_ms;
  bit          supply_fault;
  int unsigned countdown;
  bit          dig_valid;

  result_t     status_due[$];
  int          errors;
  int          n_ticks;

  function new();
    test_len     = 32'(TEST_LEN_RST);
    outage_lim   = 32'(OUTAGE_LIM_RST);
    outage_ms    = 0;
    supply_fault = 0;
    countdown    = 0;
    dig_valid    = 0;
    errors       = 0;
    n_ticks      = 0;
  endfunction

  function void set_reg(reg_idx_t idx, logic [15:0] v);
    case (idx)
      REG_TEST_LEN:   test_len = 32'(v);
      REG_OUTAGE_LIM: outage_lim = 32'(v);
      default: ;
    endcase
  endfunction

  // Advance the monitor by one accepted tick and queue the status it causes.
  function void note_tick(item_t it);
    int          elapsed;
    int unsigned dms;
    bit          done_test;
    bit          ap_on;
    bit          athr_on;
    bit          ok;
    result_t     r;
    ap_on   = 0;
    athr_on = 0;
    dms     = 32'(it.delta_ms);
    n_ticks++;
    if (!it.powered) begin
      outage_ms += dms;
      if (outage_ms > 65535) outage_ms = 65535;
    end
    if (outage_ms > outage_lim) supply_fault = 1;
    if (it.powered && supply_fault) begin
      supply_fault = 0;
      if (it.gear_pressed_own && it.gear_pressed_opposite) countdown = test_len;
      outage_ms = 0;
    end
    if (countdown > 0) countdown = (countdown > dms) ? countdown - dms : 0;
    done_test = (countdown == 0);
    if (!done_test) begin
      // negative when the length was lowered below the countdown
      elapsed = int'(test_len) - int'(countdown);
      ap_on = (elapsed >= 24700 && elapsed <= 25180) || (elapsed >= 25230 && elapsed <= 25350) ||
              (elapsed >= 25460 && elapsed <= 25550) || (elapsed >= 25620 && elapsed <= 25750) ||
              (elapsed >= 25800 && elapsed <= 25950);
      athr_on = (elapsed >= 26160 && elapsed <= 26600) ||
                (elapsed >= 26700 && elapsed <= 26850) ||
                (elapsed >= 26960 && elapsed <= 27050) ||
                (elapsed >= 27110 && elapsed <= 27220) ||
                (elapsed >= 27320 && elapsed <= 27720);
      dig_valid = (elapsed >= 25230 && elapsed <= 28200) ||
                  (elapsed >= 29350 && elapsed <= 29750);
    end
    ok = !it.fault_active && !supply_fault && done_test;
    r.healthy      = ok;
    r.ap_light     = !ok && !done_test && ap_on;
    r.athr_light   = !ok && !done_test && athr_on;
    r.bus_status   = ok ? BUS_NORMAL : (dig_valid ? BUS_FUNC_TEST : BUS_FAIL_WARN);
    r.test_running = (countdown > 0);
    status_due.push_back(r);
  endfunction

  function void report(string field, int e, int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
      errors++;
    end
  endfunction

  // Compare one status word from the block with the oldest prediction.
  function void check_status(logic [7:0] d);
    result_t e;
    if (status_due.size() == 0) begin
      $display("%0t: unexpected status, expected none, actual %h", $time, d);
      errors++;
      return;
    end
    e = status_due.pop_front();
    report("healthy", int'(e.healthy), int'(d[0]));
    report("ap_light", int'(e.ap_light), int'(d[1]));
    report("athr_light", int'(e.athr_light), int'(d[2]));
    report("bus_status", int'(e.bus_status), int'(d[4:3]));
    report("test_running", int'(e.test_running), int'(d[5]));
  endfunction
endclass

module power_monitor_self_test_sequencer_core_tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [9:0] delta_ms, [10] powered, [11] fault_active, [12] gear_pressed_own,
  // [13] gear_pressed_opposite, [15:14] zero
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [0] healthy, [1] ap_light, [2] athr_light, [4:3] bus_status,
  // [5] test_running, [7:6] zero
  logic [7:0]  out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sequencer_scoreboard sb = new();

  bit quiet;        // no idling on either side
  bit starve_out;   // ask the receiver for one long hold-off

  power_monitor_self_test_sequencer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Result side: status words are checked at the edge that accepts them.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_status(out_tdata);
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // block fills up and pushes back on the input side.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (starve_out) begin
        out_tready <= 1'b0;
        repeat (60) @(negedge clk);
        starve_out = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // One tick request; returns once the block has taken it.
  task automatic send_tick(int unsigned delta, bit pw, bit flt, bit own, bit opp);
    item_t it;
    it.delta_ms              = delta[9:0];
    it.powered               = pw;
    it.fault_active          = flt;
    it.gear_pressed_own      = own;
    it.gear_pressed_opposite = opp;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, it.gear_pressed_opposite, it.gear_pressed_own, it.fault_active,
                  it.powered, it.delta_ms};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(it);
  endtask

  // Stop sending and wait for every predicted status, plus pipeline slack.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write followed by a read-back; junk in the upper half is ignored.
  task automatic cfg_write(reg_idx_t idx, logic [15:0] v);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {junk, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {16'h0000, v}) begin
      $display("%0t: register %0d read-back, expected %h, actual %h", $time, idx,
               {16'h0000, v}, cfg_prdata);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Unconstrained ticks, full delta range including values past 1000.
  task automatic send_noise(int n);
    repeat (n) send_tick($urandom_range(0, 1023), 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom));
  endtask

  // Arm and run one self test: outage until the fault latches, a powered tick
  // with the gear down, then small steps through the window region. Brief
  // outages and injected faults are mixed in; a few arming ticks leave one
  // gear flag up so the test never starts.
  task automatic run_self_test();
    int unsigned n;
    int          elapsed;
    bit          own;
    bit          opp;
    n = 0;
    while (!sb.supply_fault && n < 80) begin
      send_tick($urandom_range(1, 1000), 1'b0, $urandom_range(0, 9) == 0,
                1'($urandom), 1'($urandom));
      n++;
    end
    own = 1'b1;
    opp = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) own = 1'b0;
      else opp = 1'b0;
    end
    send_tick($urandom_range(0, 300), 1'b1, $urandom_range(0, 9) == 0, own, opp);
    n = 0;
    while (sb.countdown > 0 && n < 400) begin
      elapsed = int'(sb.test_len) - int'(sb.countdown);
      if ($urandom_range(0, 32) == 0)
        send_tick($urandom_range(1, 8), 1'b0, 1'b0, 1'b1, 1'b1);
      else if (elapsed < 24000)
        send_tick($urandom_range(400, 1000), 1'b1, $urandom_range(0, 9) == 0,
                  1'($urandom), 1'($urandom));
      else
        send_tick($urandom_range(1, 120), 1'b1, $urandom_range(0, 9) == 0,
                  1'($urandom), 1'($urandom));
      n++;
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    quiet       = 0;
    starve_out  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings (30000 ms test, 10 ms outage limit).
    send_tick(0, 1'b0, 1'b1, 1'b1, 1'b1);     // zero tick with external fault
    send_tick(10, 1'b0, 1'b0, 1'b0, 1'b0);    // outage at the limit, no latch
    send_tick(1, 1'b0, 1'b0, 1'b0, 1'b0);     // one past the limit latches
    send_tick(5, 1'b1, 1'b0, 1'b1, 1'b0);     // release, own gear only
    send_tick(1023, 1'b0, 1'b0, 1'b1, 1'b1);  // largest delta, unpowered
    send_tick(7, 1'b1, 1'b0, 1'b0, 1'b1);     // release, opposite gear only
    send_tick(1000, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(0, 1'b1, 1'b0, 1'b1, 1'b1);     // release with gear down starts test
    send_tick(1023, 1'b1, 1'b1, 1'b1, 1'b1);  // test running with a fault
    send_tick(1000, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(3, 1'b0, 1'b0, 1'b1, 1'b1);     // brief outage mid-test
    send_tick(512, 1'b1, 1'b0, 1'b1, 1'b1);   // powered, not latched: no reload

    // Default settings; the receiver holds off during the first test.
    starve_out = 1;
    run_self_test();
    // sender pauses until every status is back
    drain();
    run_self_test();
    send_noise(40);
    drain();

    // Outage saturates: the largest limit can never be exceeded.
    cfg_write(REG_TEST_LEN, 16'hFFFF);
    cfg_write(REG_OUTAGE_LIM, 16'hFFFF);
    repeat (70) send_tick($urandom_range(1000, 1023), 1'b0, 1'($urandom), 1'($urandom),
                          1'($urandom));
    drain();
    // Limit dropped to zero while powered: latch and release in one tick.
    cfg_write(REG_OUTAGE_LIM, 16'h0000);
    send_tick(0, 1'b1, 1'b0, 1'b1, 1'b1);
    repeat (5) send_tick(1000, 1'b1, 1'b0, 1'b1, 1'b1);
    drain();
    // Length lowered mid-test: elapsed goes negative until the countdown ends.
    cfg_write(REG_TEST_LEN, 16'd100);
    while (sb.countdown > 0)
      send_tick($urandom_range(700, 1023), 1'b1, 1'($urandom), 1'b1, 1'b1);
    drain();

    // Zero length: arming loads nothing and no test runs.
    cfg_write(REG_TEST_LEN, 16'h0000);
    cfg_write(REG_OUTAGE_LIM, 16'd5);
    send_tick(6, 1'b0, 1'b0, 1'b1, 1'b1);
    send_tick(0, 1'b1, 1'b0, 1'b1, 1'b1);
    send_tick(0, 1'b1, 1'b0, 1'b1, 1'b1);
    send_noise(8);
    drain();

    // Random settings.
    repeat (2) begin
      cfg_write(REG_TEST_LEN, 16'($urandom_range(24800, 30500)));
      cfg_write(REG_OUTAGE_LIM, 16'($urandom_range(0, 3000)));
      send_noise(40);
      run_self_test();
      drain();
    end

    // Closing stretch with no idling anywhere.
    cfg_write(REG_TEST_LEN, 16'($urandom_range(26000, 30500)));
    cfg_write(REG_OUTAGE_LIM, 16'($urandom_range(0, 50)));
    quiet = 1;
    run_self_test();
    send_noise(30);
    drain();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.status_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
